// ===== rtl/tbpm_pkg.sv =====
`timescale 1ns / 1ps

package tbpm_pkg;

  // Structure characters
  localparam logic [7:0] SYM_ROUND_OPEN   = 8'h28;
  localparam logic [7:0] SYM_ROUND_CLOSE  = 8'h29;
  localparam logic [7:0] SYM_SQUARE_OPEN  = 8'h5B;
  localparam logic [7:0] SYM_SQUARE_CLOSE = 8'h5D;

  // Sticky error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_ROUND_UNDER  = 3'd1;
  localparam logic [2:0] ERR_SQUARE_UNDER = 3'd2;
  localparam logic [2:0] ERR_ROUND_OPEN   = 3'd3;
  localparam logic [2:0] ERR_SQUARE_OPEN  = 3'd4;
  localparam logic [2:0] ERR_TOO_LONG     = 3'd5;

  // Output field widths
  localparam int unsigned POS_FIELD_W = 11;
  localparam int unsigned ERR_FIELD_W = 3;

  // Command class handed from front to back
  typedef enum logic [2:0] {
    OP_NONE        = 3'd0,
    OP_ROUND_PUSH  = 3'd1,
    OP_ROUND_POP   = 3'd2,
    OP_SQUARE_PUSH = 3'd3,
    OP_SQUARE_POP  = 3'd4,
    OP_TOO_LONG    = 3'd5
  } op_t;

  localparam int unsigned OP_W = 3;

  // Stack control from back to one stack
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stk_ctrl_t;

  // Stack status from one stack to back
  typedef struct packed {
    logic empty;
    logic single;
  } stk_status_t;

endpackage

// ===== rtl/tbpm_ram.sv =====
`timescale 1ns / 1ps

module tbpm_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tbpm_fifo.sv =====
`timescale 1ns / 1ps

module tbpm_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold words in the slots
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/tbpm_stack.sv =====
`timescale 1ns / 1ps

module tbpm_stack #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned PW    = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tbpm_pkg::stk_ctrl_t   ctrl,
  input  logic [PW-1:0]         push_data,
  output logic [PW-1:0]         top,
  output tbpm_pkg::stk_status_t status
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned DW = $clog2(DEPTH + 1);

  logic [DW-1:0] depth_r, depth_nxt;
  logic [PW-1:0] top_r, top_nxt;
  logic          byp_r;
  logic [PW-1:0] byp_data_r;
  logic [PW-1:0] under;
  logic [PW-1:0] rdata;
  logic          we;
  logic [DW-1:0] waddr_full;
  logic [DW-1:0] raddr_full;

  assign top           = top_r;
  assign status.empty  = (depth_r == '0);
  assign status.single = (depth_r == DW'(1));

  // The entry just below the top: from the RAM, or the old top after a push
  assign under = byp_r ? byp_data_r : rdata;

  // Next depth and top
  always_comb begin
    depth_nxt = depth_r;
    top_nxt   = top_r;
    if (ctrl.push) begin
      depth_nxt = depth_r + DW'(1);
      top_nxt   = push_data;
    end else if (ctrl.pop) begin
      depth_nxt = depth_r - DW'(1);
      top_nxt   = under;
    end
    if (ctrl.clear) begin
      depth_nxt = '0;
    end
  end

  // Spill the old top below on a push; prefetch the entry under the next top
  assign we         = ctrl.push && (depth_r != '0);
  assign waddr_full = depth_r - DW'(1);
  assign raddr_full = depth_nxt - DW'(2);

  tbpm_ram #(
    .WIDTH(PW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr_full[AW-1:0]),
    .wdata(top_r),
    .raddr(raddr_full[AW-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      byp_r   <= 1'b0;
    end else begin
      depth_r <= depth_nxt;
      byp_r   <= ctrl.push;
    end
  end

  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    byp_data_r <= top_r;
  end

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DW'(DEPTH))
    else $error("stack depth beyond capacity");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |-> !status.empty)
    else $error("pop on empty stack");

  a_push_top: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.push |=> top_r == $past(push_data))
    else $error("pushed position not on top");

  a_clear_depth: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.clear |=> depth_r == '0)
    else $error("stack not cleared at end of structure");
`endif

endmodule

// ===== rtl/tbpm_front.sv =====
`timescale 1ns / 1ps

module tbpm_front #(
  parameter int unsigned MAX_LENGTH = 1024,
  parameter int unsigned PW         = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  logic [7:0]                    in_symbol,
  input  logic                          in_is_last,
  input  logic                          q_full,
  output logic                          q_push,
  output logic [tbpm_pkg::OP_W+PW:0]    q_data
);

  localparam logic [PW-1:0] MAX_POS = PW'(MAX_LENGTH);

  logic [PW-1:0]   cnt_r, cnt_nxt;
  logic [PW-1:0]   pos;
  tbpm_pkg::op_t   op;
  logic            accept;

  assign accept = in_push && !q_full;
  assign q_push = accept;

  // Saturate the position one past the maximum length
  assign pos = (cnt_r <= MAX_POS) ? cnt_r + PW'(1) : cnt_r;

  // Classify the character
  always_comb begin
    if (pos > MAX_POS) begin
      op = tbpm_pkg::OP_TOO_LONG;
    end else begin
      case (in_symbol)
        tbpm_pkg::SYM_ROUND_OPEN:   op = tbpm_pkg::OP_ROUND_PUSH;
        tbpm_pkg::SYM_ROUND_CLOSE:  op = tbpm_pkg::OP_ROUND_POP;
        tbpm_pkg::SYM_SQUARE_OPEN:  op = tbpm_pkg::OP_SQUARE_PUSH;
        tbpm_pkg::SYM_SQUARE_CLOSE: op = tbpm_pkg::OP_SQUARE_POP;
        default:                    op = tbpm_pkg::OP_NONE;
      endcase
    end
  end

  assign q_data = {op, in_is_last, pos};

  // Advance the counter; restart after the last character
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = in_is_last ? '0 : pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/tbpm_back.sv =====
`timescale 1ns / 1ps

module tbpm_back #(
  parameter int unsigned MAX_LENGTH = 1024,
  parameter int unsigned PW         = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tbpm_pkg::OP_W+PW:0]    cmd_data,
  input  logic                          cmd_empty,
  output logic                          cmd_pop,
  input  logic                          res_full,
  output logic                          res_push,
  output logic [2*PW+3:0]               res_data
);

  tbpm_pkg::op_t         op;
  logic                  last;
  logic [PW-1:0]         pos;
  logic                  fire;
  tbpm_pkg::stk_ctrl_t   r_ctrl, s_ctrl;
  tbpm_pkg::stk_status_t r_stat, s_stat;
  logic [PW-1:0]         r_top, s_top;
  logic [PW-1:0]         partner;
  logic [2:0]            op_err, end_err, err_out;
  logic [2:0]            err_r, err_nxt;
  logic                  r_left, s_left;

  // Unpack the command
  assign op   = tbpm_pkg::op_t'(cmd_data[tbpm_pkg::OP_W+PW:PW+1]);
  assign last = cmd_data[PW];
  assign pos  = cmd_data[PW-1:0];

  assign fire     = !cmd_empty && !res_full;
  assign cmd_pop  = fire;
  assign res_push = fire;

  // Drive the two stacks
  always_comb begin
    r_ctrl.push  = fire && (op == tbpm_pkg::OP_ROUND_PUSH);
    r_ctrl.pop   = fire && (op == tbpm_pkg::OP_ROUND_POP) && !r_stat.empty;
    r_ctrl.clear = fire && last;
    s_ctrl.push  = fire && (op == tbpm_pkg::OP_SQUARE_PUSH);
    s_ctrl.pop   = fire && (op == tbpm_pkg::OP_SQUARE_POP) && !s_stat.empty;
    s_ctrl.clear = fire && last;
  end

  tbpm_stack #(.DEPTH(MAX_LENGTH), .PW(PW)) u_round (
    .clk(clk), .rst_n(rst_n), .ctrl(r_ctrl), .push_data(pos),
    .top(r_top), .status(r_stat)
  );

  tbpm_stack #(.DEPTH(MAX_LENGTH), .PW(PW)) u_square (
    .clk(clk), .rst_n(rst_n), .ctrl(s_ctrl), .push_data(pos),
    .top(s_top), .status(s_stat)
  );

  // Partner and error from this character
  always_comb begin
    partner = '0;
    op_err  = tbpm_pkg::ERR_NONE;
    case (op)
      tbpm_pkg::OP_ROUND_POP: begin
        if (r_stat.empty) begin
          op_err = tbpm_pkg::ERR_ROUND_UNDER;
        end else begin
          partner = r_top;
        end
      end
      tbpm_pkg::OP_SQUARE_POP: begin
        if (s_stat.empty) begin
          op_err = tbpm_pkg::ERR_SQUARE_UNDER;
        end else begin
          partner = s_top;
        end
      end
      tbpm_pkg::OP_TOO_LONG: op_err = tbpm_pkg::ERR_TOO_LONG;
      default: ;
    endcase
  end

  // Stack occupancy left after this character
  always_comb begin
    case (op)
      tbpm_pkg::OP_ROUND_PUSH: r_left = 1'b1;
      tbpm_pkg::OP_ROUND_POP:  r_left = !r_stat.empty && !r_stat.single;
      default:                 r_left = !r_stat.empty;
    endcase
    case (op)
      tbpm_pkg::OP_SQUARE_PUSH: s_left = 1'b1;
      tbpm_pkg::OP_SQUARE_POP:  s_left = !s_stat.empty && !s_stat.single;
      default:                  s_left = !s_stat.empty;
    endcase
  end

  // Unclosed brackets at the last character, round first
  always_comb begin
    end_err = tbpm_pkg::ERR_NONE;
    if (last) begin
      if (r_left) begin
        end_err = tbpm_pkg::ERR_ROUND_OPEN;
      end else if (s_left) begin
        end_err = tbpm_pkg::ERR_SQUARE_OPEN;
      end
    end
  end

  // First error wins; drop it after the last character
  always_comb begin
    if (err_r != tbpm_pkg::ERR_NONE) begin
      err_out = err_r;
    end else if (op_err != tbpm_pkg::ERR_NONE) begin
      err_out = op_err;
    end else begin
      err_out = end_err;
    end
    err_nxt = err_r;
    if (fire) begin
      err_nxt = last ? tbpm_pkg::ERR_NONE : err_out;
    end
  end

  assign res_data = {pos, partner, err_out, last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= tbpm_pkg::ERR_NONE;
    end else begin
      err_r <= err_nxt;
    end
  end

`ifndef SYNTHESIS
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (err_r != tbpm_pkg::ERR_NONE) |-> err_out == err_r)
    else $error("sticky error code overwritten");

  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    fire && last |=> err_r == tbpm_pkg::ERR_NONE)
    else $error("error code kept past end of structure");

  a_partner_closer: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (partner != '0) |->
      (op == tbpm_pkg::OP_ROUND_POP) || (op == tbpm_pkg::OP_SQUARE_POP))
    else $error("partner reported for a non-closer");
`endif

endmodule

// ===== rtl/two_bracket_pair_matcher_top.sv =====
`timescale 1ns / 1ps

// Two-kind bracket pair matcher.
// Input queue: drive in_symbol and in_is_last with in_push; a word is taken
// on a clock edge with in_push high and in_full low. One result word comes
// out per character, in order, on the out_ ports while out_empty is low; it
// is taken on an edge with out_pop high.
// Each result gives the 1-based position, the partner opener position for a
// closer (0 otherwise), the sticky error code and done_res on the last
// character. After the last character all counters and error state restart.
// Throughput: one character per cycle while out_pop stays high. A character
// waits in a two-word command queue, the stack stage handles it as it leaves
// that queue, and its result waits in a two-word result queue, from which it
// shows on the out_ ports.
// The stack top lives in a register and the next entry is prefetched from
// the stack RAM each cycle, so any mix of pushes and pops runs back to back.
// When out_pop stays low the result queue fills, the stack stage halts, then
// the command queue fills and in_full rises; nothing is dropped.
// Reset (rst_n low, synchronous) empties both queues and clears position,
// stack depths and error; stack RAM contents need no clearing.

module two_bracket_pair_matcher_top #(
  parameter int unsigned MAX_LENGTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_symbol,
  input  logic        in_is_last,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [10:0] out_position,
  output logic [10:0] out_partner,
  output logic [2:0]  out_error_code,
  output logic        out_done_res
);

  localparam int unsigned PW    = $clog2(MAX_LENGTH + 2);
  localparam int unsigned CMD_W = tbpm_pkg::OP_W + PW + 1;
  localparam int unsigned RES_W = 2 * PW + 4;

  logic             fq_push, fq_full, bq_pop, bq_empty;
  logic [CMD_W-1:0] fq_data, bq_data;
  logic             rq_push, rq_full;
  logic [RES_W-1:0] rq_wdata, rq_rdata;
  logic [PW-1:0]    res_pos, res_partner;

  tbpm_front #(.MAX_LENGTH(MAX_LENGTH), .PW(PW)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_symbol(in_symbol), .in_is_last(in_is_last),
    .q_full(fq_full), .q_push(fq_push), .q_data(fq_data)
  );

  assign in_full = fq_full;

  // Command queue between front and back
  tbpm_fifo #(.WIDTH(CMD_W)) u_cmd_q (
    .clk(clk), .rst_n(rst_n),
    .push(fq_push), .wdata(fq_data), .full(fq_full),
    .pop(bq_pop), .rdata(bq_data), .empty(bq_empty)
  );

  tbpm_back #(.MAX_LENGTH(MAX_LENGTH), .PW(PW)) u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_data(bq_data), .cmd_empty(bq_empty), .cmd_pop(bq_pop),
    .res_full(rq_full), .res_push(rq_push), .res_data(rq_wdata)
  );

  // Result queue toward the receiver
  tbpm_fifo #(.WIDTH(RES_W)) u_res_q (
    .clk(clk), .rst_n(rst_n),
    .push(rq_push), .wdata(rq_wdata), .full(rq_full),
    .pop(out_pop), .rdata(rq_rdata), .empty(out_empty)
  );

  // Fit positions to the result fields
  assign res_pos        = rq_rdata[2*PW+3:PW+4];
  assign res_partner    = rq_rdata[PW+3:4];
  assign out_position   = tbpm_pkg::POS_FIELD_W'(res_pos);
  assign out_partner    = tbpm_pkg::POS_FIELD_W'(res_partner);
  assign out_error_code = rq_rdata[3:1];
  assign out_done_res   = rq_rdata[0];

endmodule

// ===== tb/two_bracket_pair_matcher_top_test.sv =====
`timescale 1ns / 1ps

module two_bracket_pair_matcher_top_test;

  localparam int unsigned MAX_LEN      = 1024;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned RANDOM_CHARS = 300;

  typedef struct packed {
    logic [tbpm_pkg::POS_FIELD_W-1:0] position;
    logic [tbpm_pkg::POS_FIELD_W-1:0] partner;
    logic [tbpm_pkg::ERR_FIELD_W-1:0] error_code;
    logic                             done_res;
  } pair_word_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_push    = 1'b0;
  logic [7:0]  in_symbol  = 8'h00;
  logic        in_is_last = 1'b0;
  logic        out_pop    = 1'b0;
  logic        in_full;
  logic        out_empty;
  logic [10:0] out_position;
  logic [10:0] out_partner;
  logic [2:0]  out_error_code;
  logic        out_done_res;

  // Pair table tracking: position, open bracket positions per kind, first error
  logic [tbpm_pkg::POS_FIELD_W-1:0] char_pos = '0;
  logic [tbpm_pkg::POS_FIELD_W-1:0] round_opens[$];
  logic [tbpm_pkg::POS_FIELD_W-1:0] square_opens[$];
  logic [tbpm_pkg::ERR_FIELD_W-1:0] first_error = tbpm_pkg::ERR_NONE;
  pair_word_t                       pending_pairs[$];

  int send_idle_pct = 0;
  int take_idle_pct = 0;
  int error_cnt     = 0;
  int stall_cnt     = 0;
  int chars_sent    = 0;

  two_bracket_pair_matcher_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_symbol      (in_symbol),
    .in_is_last     (in_is_last),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_position   (out_position),
    .out_partner    (out_partner),
    .out_error_code (out_error_code),
    .out_done_res   (out_done_res)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Keep only the first error of a structure
  function automatic void record_error(input logic [tbpm_pkg::ERR_FIELD_W-1:0] code);
    if (first_error == tbpm_pkg::ERR_NONE) first_error = code;
  endfunction

  // Work out the result word for one accepted character and queue it
  function automatic void track_char(input logic [7:0] sym, input logic last);
    pair_word_t w;
    w = '0;
    if (char_pos < MAX_LEN + 1) char_pos = char_pos + 1'b1;
    w.position = char_pos;
    if (char_pos > MAX_LEN) begin
      record_error(tbpm_pkg::ERR_TOO_LONG);
    end else begin
      case (sym)
        tbpm_pkg::SYM_ROUND_OPEN: begin
          if (round_opens.size() < MAX_LEN) round_opens.push_back(char_pos);
        end
        tbpm_pkg::SYM_ROUND_CLOSE: begin
          if (round_opens.size() == 0) record_error(tbpm_pkg::ERR_ROUND_UNDER);
          else w.partner = round_opens.pop_back();
        end
        tbpm_pkg::SYM_SQUARE_OPEN: begin
          if (square_opens.size() < MAX_LEN) square_opens.push_back(char_pos);
        end
        tbpm_pkg::SYM_SQUARE_CLOSE: begin
          if (square_opens.size() == 0) record_error(tbpm_pkg::ERR_SQUARE_UNDER);
          else w.partner = square_opens.pop_back();
        end
        default: ;
      endcase
    end
    // Check for unclosed brackets once the last character is handled
    if (last) begin
      if (round_opens.size() != 0) record_error(tbpm_pkg::ERR_ROUND_OPEN);
      else if (square_opens.size() != 0) record_error(tbpm_pkg::ERR_SQUARE_OPEN);
    end
    w.error_code = first_error;
    w.done_res   = last;
    pending_pairs.push_back(w);
    // Start the next structure from a clean state
    if (last) begin
      char_pos    = '0;
      first_error = tbpm_pkg::ERR_NONE;
      round_opens.delete();
      square_opens.delete();
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      error_cnt++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Check each popped word against the oldest pending one, then pick next pop
  always @(posedge clk) begin : check_words
    pair_word_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_pairs.size() == 0) begin
        error_cnt++;
        $display("%0t: unexpected word, expected none, actual position %0d partner %0d",
                 $time, out_position, out_partner);
      end else begin
        want = pending_pairs.pop_front();
        check_field("position", want.position, out_position);
        check_field("partner", want.partner, out_partner);
        check_field("error_code", want.error_code, out_error_code);
        check_field("done_res", want.done_res, out_done_res);
      end
    end
    out_pop <= rst_n && ($urandom_range(0, 99) >= take_idle_pct);
  end

  // End the run when no word moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("two_bracket_pair_matcher_top_test: errors");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // Push one character, idling at random first
  task automatic send_char(input logic [7:0] sym, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push    <= 1'b1;
    in_symbol  <= sym;
    in_is_last <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    track_char(sym, last);
    chars_sent++;
  endtask

  task automatic send_text(input string s, input bit last);
    for (int i = 0; i < s.len(); i++) send_char(s[i], last && (i == s.len() - 1));
  endtask

  // Hold off input until every pending word has come out
  task automatic hold_until_drained();
    in_push <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
  endtask

  task automatic test_nested_pairs();
    send_char(8'h00, 1'b0);
    send_text("([", 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("])", 1'b1);
    send_text(".", 1'b1);
    send_text("([)]", 1'b1);
  endtask

  // Closers on empty stacks; the first error holds and pairing goes on
  task automatic test_underflow();
    send_text(")()]", 1'b1);
    send_text("[]](", 1'b1);
  endtask

  // Openers left at the end; round wins over square
  task automatic test_unclosed();
    send_text("[((", 1'b1);
    send_text("[x", 1'b1);
    send_text("(", 1'b1);
  endtask

  // Fill a structure to the length limit with deep stacks, then overrun it
  task automatic test_too_long();
    repeat (300) send_char(tbpm_pkg::SYM_ROUND_OPEN, 1'b0);
    repeat (212) send_char(tbpm_pkg::SYM_SQUARE_OPEN, 1'b0);
    repeat (212) send_char(tbpm_pkg::SYM_SQUARE_CLOSE, 1'b0);
    repeat (300) send_char(tbpm_pkg::SYM_ROUND_CLOSE, 1'b0);
    send_text("()[]", 1'b1);
  endtask

  // Build one mostly well-formed structure; some get random edits
  task automatic send_random_structure();
    logic [7:0] syms[$];
    logic       open_kinds[$];
    logic [7:0] b;
    int         len;
    int         pick;
    int         idx;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 250) : $urandom_range(1, 32);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (open_kinds.size() >= len - i || (open_kinds.size() != 0 && pick < 35)) begin
        syms.push_back(open_kinds.pop_back() ? tbpm_pkg::SYM_SQUARE_CLOSE
                                             : tbpm_pkg::SYM_ROUND_CLOSE);
      end else if (pick < 80 && open_kinds.size() + 1 < len - i) begin
        open_kinds.push_back(pick[0]);
        syms.push_back(pick[0] ? tbpm_pkg::SYM_SQUARE_OPEN : tbpm_pkg::SYM_ROUND_OPEN);
      end else begin
        do b = 8'($urandom_range(0, 255));
        while (b inside {tbpm_pkg::SYM_ROUND_OPEN, tbpm_pkg::SYM_ROUND_CLOSE,
                         tbpm_pkg::SYM_SQUARE_OPEN, tbpm_pkg::SYM_SQUARE_CLOSE});
        syms.push_back(b);
      end
    end
    // Break about one in five with stray brackets and bytes
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, len / 4 + 1)) begin
        idx = $urandom_range(0, len - 1);
        case ($urandom_range(0, 7))
          0: syms[idx] = tbpm_pkg::SYM_ROUND_OPEN;
          1: syms[idx] = tbpm_pkg::SYM_ROUND_CLOSE;
          2: syms[idx] = tbpm_pkg::SYM_SQUARE_OPEN;
          3: syms[idx] = tbpm_pkg::SYM_SQUARE_CLOSE;
          default: syms[idx] = 8'($urandom_range(0, 255));
        endcase
      end
    end
    foreach (syms[i]) send_char(syms[i], i == syms.size() - 1);
  endtask

  task automatic test_random_phase(input int s_pct, input int t_pct, input int n_chars);
    int start;
    hold_until_drained();
    send_idle_pct = s_pct;
    take_idle_pct = t_pct;
    start = chars_sent;
    while (chars_sent - start < n_chars) send_random_structure();
  endtask

  initial begin
    send_idle_pct = 12;
    take_idle_pct = 48;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_nested_pairs();
    test_underflow();
    test_unclosed();
    test_too_long();
    test_random_phase(12, 48, RANDOM_CHARS / 3);
    test_random_phase(48, 12, RANDOM_CHARS / 3);
    test_random_phase(0, 0, RANDOM_CHARS / 3);
    hold_until_drained();
    repeat (10) @(posedge clk);
    if (error_cnt == 0) begin
      $display("two_bracket_pair_matcher_top_test: clean");
    end else begin
      $display("two_bracket_pair_matcher_top_test: errors");
    end
    $finish;
  end

endmodule

// ===== two_bracket_pair_matcher_top.f =====
rtl/tbpm_pkg.sv
rtl/tbpm_ram.sv
rtl/tbpm_fifo.sv
rtl/tbpm_stack.sv
rtl/tbpm_front.sv
rtl/tbpm_back.sv
rtl/two_bracket_pair_matcher_top.sv
tb/two_bracket_pair_matcher_top_test.sv
